// File: src/spfq_pkg.sv
`timescale 1ns / 1ps

package spfq_pkg;

    localparam int FRAME_W = 16;
    localparam int LEVEL_W = 4;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

// File: src/spfq_prio_enc.sv
`timescale 1ns / 1ps

module spfq_prio_enc #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]         req,
    output logic                     any,
    output logic [$clog2(WIDTH)-1:0] idx
);

    localparam int IDX_W = $clog2(WIDTH);

    // lowest set bit wins: level 0 is the highest priority
    always_comb
    begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (req[i])
            begin
                idx = IDX_W'(i);
            end
        end
        any = |req;
    end

endmodule

// File: src/strict_priority_fifo_queue_top.sv
`timescale 1ns / 1ps

// Channel  Signals                          Direction  Payload
// -------  -------------------------------  ---------  ------------------------------
// in       in_valid / in_ready              sink       op, level, frame_in
// out      out_valid / out_ready            source     frame_out, status, queue_empty
//
// One item per cycle sustained while out_ready is high; a taken item passes through the
// input register and then the result register, which loads when the item advances.
// The handle store and link memories are read in advance at the head of the top
// level and at the free head, with write-first bypass, so back-to-back pops need no gap.
// Reset clears the level bitmap and the counters at once; there is no clearing pass.
// A stalled result holds the input register; in_ready drops only when both are full.

module strict_priority_fifo_queue_top
    import spfq_pkg::*;
#(
    parameter int LEVELS       = 16,
    parameter int CAPACITY     = 64,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [LEVEL_W-1:0] level,
    input  logic [FRAME_W-1:0] frame_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FRAME_W-1:0] frame_out,
    output logic [1:0]         status,
    output logic               queue_empty
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LVL_W = $clog2(LEVELS);

    // input register
    logic               item_valid_reg;
    op_t                op_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [FRAME_W-1:0] frame_reg;

    // result register
    logic               out_valid_reg;
    logic [FRAME_W-1:0] frame_out_reg;
    status_t            status_reg;
    logic               qempty_reg;

    // queue state
    logic [LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [IDX_W-1:0]  head_reg [LEVELS];
    logic [IDX_W-1:0]  tail_reg [LEVELS];
    logic [IDX_W-1:0]  free_head_reg, free_head_next;
    logic [IDX_W-1:0]  top_head_reg, top_head_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  hwm_reg, hwm_next;

    // memories
    logic [HANDLE_WIDTH-1:0] hs_mem [CAPACITY];
    logic [IDX_W-1:0]        nl_mem [CAPACITY];

    logic [HANDLE_WIDTH-1:0] hs_rd_reg, hs_bypd_reg, hs_top;
    logic                    hs_byp_reg;
    logic [IDX_W-1:0]        nl_top_rd_reg, nl_top_bypd_reg, nl_top;
    logic                    nl_top_byp_reg;
    logic [IDX_W-1:0]        nl_free_rd_reg, nl_free_bypd_reg, nl_free;
    logic                    nl_free_byp_reg;

    // write controls
    logic                    hs_we;
    logic [IDX_W-1:0]        hs_waddr;
    logic [HANDLE_WIDTH-1:0] hs_wdata;
    logic                    nl_we;
    logic [IDX_W-1:0]        nl_waddr;
    logic [IDX_W-1:0]        nl_wdata;
    logic                    head_we;
    logic [LVL_W-1:0]        head_wlvl;
    logic [IDX_W-1:0]        head_wdata;
    logic                    tail_we;
    logic [LVL_W-1:0]        tail_wlvl;
    logic [IDX_W-1:0]        tail_wdata;

    // working signals
    logic               advance;
    logic               cur_any, nxt_any;
    logic [LVL_W-1:0]   cur_top, nxt_top;
    logic [LVL_W-1:0]   ins_lvl;
    logic [LVL_W-1:0]   tail_ridx;
    logic [IDX_W-1:0]   tail_rd;
    logic               fresh;
    logic [IDX_W-1:0]   alloc_slot;
    status_t            res_status;
    logic [FRAME_W-1:0] res_frame;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    assign out_valid   = out_valid_reg;
    assign frame_out   = frame_out_reg;
    assign status      = status_reg;
    assign queue_empty = qempty_reg;

    spfq_prio_enc #(
        .WIDTH (LEVELS)
    ) u_cur_enc (
        .req (nonempty_reg),
        .any (cur_any),
        .idx (cur_top)
    );

    spfq_prio_enc #(
        .WIDTH (LEVELS)
    ) u_nxt_enc (
        .req (nonempty_next),
        .any (nxt_any),
        .idx (nxt_top)
    );

    // saturate out-of-range levels to the lowest priority
    always_comb
    begin
        if (int'(level_reg) >= LEVELS)
        begin
            ins_lvl = LVL_W'(LEVELS - 1);
        end
        else
        begin
            ins_lvl = LVL_W'(level_reg);
        end
    end

    assign tail_ridx = (op_reg == OP_POP) ? cur_top : ins_lvl;
    assign tail_rd   = tail_reg[tail_ridx];

    // slots below the high-water mark not in use sit on the free list
    assign fresh      = (occ_reg == hwm_reg);
    assign alloc_slot = fresh ? hwm_reg[IDX_W-1:0] : free_head_reg;

    assign hs_top  = hs_byp_reg ? hs_bypd_reg : hs_rd_reg;
    assign nl_top  = nl_top_byp_reg ? nl_top_bypd_reg : nl_top_rd_reg;
    assign nl_free = nl_free_byp_reg ? nl_free_bypd_reg : nl_free_rd_reg;

    always_comb
    begin
        nonempty_next  = nonempty_reg;
        free_head_next = free_head_reg;
        occ_next       = occ_reg;
        hwm_next       = hwm_reg;
        hs_we          = 1'b0;
        hs_waddr       = alloc_slot;
        hs_wdata       = HANDLE_WIDTH'(frame_reg);
        nl_we          = 1'b0;
        nl_waddr       = tail_rd;
        nl_wdata       = alloc_slot;
        head_we        = 1'b0;
        head_wlvl      = ins_lvl;
        head_wdata     = alloc_slot;
        tail_we        = 1'b0;
        tail_wlvl      = ins_lvl;
        tail_wdata     = alloc_slot;
        res_status     = STATUS_OK;
        res_frame      = '0;

        if (advance)
        begin
            if (op_reg == OP_INSERT)
            begin
                if (occ_reg == CNT_W'(CAPACITY))
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    hs_we   = 1'b1;
                    tail_we = 1'b1;
                    if (nonempty_reg[ins_lvl])
                    begin
                        nl_we = 1'b1;
                    end
                    else
                    begin
                        head_we                = 1'b1;
                        nonempty_next[ins_lvl] = 1'b1;
                    end
                    free_head_next = fresh ? free_head_reg : nl_free;
                    hwm_next       = hwm_reg + CNT_W'(fresh);
                    occ_next       = occ_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (!cur_any)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    res_frame = FRAME_W'(hs_top);
                    if (top_head_reg == tail_rd)
                    begin
                        nonempty_next[cur_top] = 1'b0;
                    end
                    else
                    begin
                        head_we    = 1'b1;
                        head_wlvl  = cur_top;
                        head_wdata = nl_top;
                    end
                    // return the slot to the front of the free list
                    nl_we          = 1'b1;
                    nl_waddr       = top_head_reg;
                    nl_wdata       = free_head_reg;
                    free_head_next = top_head_reg;
                    occ_next       = occ_reg - CNT_W'(1);
                end
            end
        end
    end

    // head of the level that the next pop will take; hold it while every level is empty
    always_comb
    begin
        if (!nxt_any)
        begin
            top_head_next = top_head_reg;
        end
        else if (head_we && (head_wlvl == nxt_top))
        begin
            top_head_next = head_wdata;
        end
        else
        begin
            top_head_next = head_reg[nxt_top];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            top_head_reg   <= '0;
            occ_reg        <= '0;
            hwm_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            nonempty_reg  <= nonempty_next;
            free_head_reg <= free_head_next;
            top_head_reg  <= top_head_next;
            occ_reg       <= occ_next;
            hwm_reg       <= hwm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= op_t'(op);
            level_reg <= level;
            frame_reg <= frame_in;
        end
        if (advance)
        begin
            frame_out_reg <= res_frame;
            status_reg    <= res_status;
            qempty_reg    <= (occ_next == '0);
        end
        if (head_we)
        begin
            head_reg[head_wlvl] <= head_wdata;
        end
        if (tail_we)
        begin
            tail_reg[tail_wlvl] <= tail_wdata;
        end
    end

    // handle store: one write port, one registered read port with write-first bypass
    always_ff @(posedge clk)
    begin
        if (hs_we)
        begin
            hs_mem[hs_waddr] <= hs_wdata;
        end
        hs_rd_reg   <= hs_mem[top_head_next];
        hs_byp_reg  <= hs_we && (hs_waddr == top_head_next);
        hs_bypd_reg <= hs_wdata;
    end

    // link memory: one write port, two registered read ports with write-first bypass
    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            nl_mem[nl_waddr] <= nl_wdata;
        end
        nl_top_rd_reg    <= nl_mem[top_head_next];
        nl_top_byp_reg   <= nl_we && (nl_waddr == top_head_next);
        nl_top_bypd_reg  <= nl_wdata;
        nl_free_rd_reg   <= nl_mem[free_head_next];
        nl_free_byp_reg  <= nl_we && (nl_waddr == free_head_next);
        nl_free_bypd_reg <= nl_wdata;
    end

`ifndef SYNTHESIS
    a_occ_below_hwm: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= hwm_reg)
        else $error("occupancy above high-water mark");

    a_bitmap_matches_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) == (nonempty_reg == '0))
        else $error("level bitmap disagrees with occupancy");

    a_empty_pop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_EMPTY) |-> queue_empty)
        else $error("empty pop without empty flag");

    a_frame_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (res_status != STATUS_OK) |=> (frame_out == '0))
        else $error("nonzero handle on a failed item");
`endif

endmodule
